// ===== rtl/core/sequence_store_with_min_max_core_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sequence store core
// Concurrent property wrappers shared by the core's checks.
// ---------------------------------------------------------------------------
`ifndef SEQUENCE_STORE_WITH_MIN_MAX_CORE_MACROS_SVH
`define SEQUENCE_STORE_WITH_MIN_MAX_CORE_MACROS_SVH

// same-cycle implication, ignored while reset is asserted
`define SSMM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssmm check failed");

// next-cycle implication, ignored while reset is asserted
`define SSMM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssmm check failed");

`endif

// ===== rtl/core/ssmm_pkg.sv =====
// ---------------------------------------------------------------------------
// ssmm_pkg
// Types and constants shared by the sequence store core.
// ---------------------------------------------------------------------------
`default_nettype none

package ssmm_pkg;

  localparam int DEPTH      = 256;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);
  localparam int CW         = $clog2(DEPTH + 1);

  typedef logic        [AW-1:0]         addr_t;
  typedef logic        [CW-1:0]         count_t;
  typedef logic signed [DATA_WIDTH-1:0] word_t;
  typedef logic signed [31:0]           field_word_t;

  typedef enum logic [2:0] {
    F_APPEND = 3'd0,
    F_INSERT = 3'd1,
    F_POP    = 3'd2,
    F_READ   = 3'd3,
    F_MAX    = 3'd4,
    F_MIN    = 3'd5,
    F_CLEAR  = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_SCAN,
    S_OUT
  } state_e;

  typedef struct packed {
    func_e       func;
    field_word_t value;
    logic [7:0]  position;
  } in_item_t;

  typedef struct packed {
    field_word_t result_value;
    status_e     status;
    logic [8:0]  occupancy;
  } out_item_t;

  // control from the sequencer to the running extreme unit
  typedef struct packed {
    logic start;   // new scan begins, next load takes the word as is
    logic load;    // read data valid this cycle
    logic is_max;  // 1: keep largest, 0: keep smallest
  } best_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ssmm_best.sv =====
// ---------------------------------------------------------------------------
// ssmm_best
// Running maximum or minimum over the words streamed out of the store.
// ---------------------------------------------------------------------------
`default_nettype none

module ssmm_best import ssmm_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire best_ctl_t ctl,
  input  wire word_t     data,
  output word_t          best_r
);

  logic  first_r;
  logic  first_nxt;
  logic  better;
  word_t best_nxt;

  always_comb begin
    better    = ctl.is_max ? (data > best_r) : (data < best_r);
    best_nxt  = best_r;
    first_nxt = first_r;
    if (ctl.start) begin
      first_nxt = 1'b1;
    end else if (ctl.load) begin
      first_nxt = 1'b0;
      if (first_r || better) begin
        best_nxt = data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
    end else begin
      first_r <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_r <= best_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/sequence_store_with_min_max_core.sv =====
// ---------------------------------------------------------------------------
// sequence_store_with_min_max_core
// Double-ended store of signed words in a ring buffer with indexed read and
// max / min query.
//
// One request is taken at a time; in_stall is low only while the core is
// idle. Append, insert, clear, pop on an empty store, the unused code and
// every request that ends in an error go from idle straight to loading the
// result register. Pop and read at position need one registered read of
// the slot memory before they load it. Max and min load it once the scan
// has streamed every stored word through the one read port, one word per
// cycle, and the last word has been folded in. A result that waits on
// out_stall sits in the output register while the next request is already
// accepted; that request finishes once the register is free.
// Status codes: ok, empty, out of range, full. Pop on an empty store reports
// ok with a zero word. Slots are not cleared by reset or clear: only words
// inside the occupied range are ever read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sequence_store_with_min_max_core_macros.svh"

module sequence_store_with_min_max_core import ssmm_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  // request channel
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  // result channel
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  // -------------------------------------------------------------------------
  // state
  // -------------------------------------------------------------------------
  state_e      state_r, state_nxt;
  addr_t       front_r;
  count_t      count_r;
  count_t      scan_idx_r;
  logic        is_max_r;
  logic        rd_vld_r;
  word_t       rd_data_r;
  field_word_t pend_res_r;
  status_e     pend_st_r;
  logic        out_valid_r;
  out_item_t   out_r;

  // slot memory, one write and one registered read per cycle
  word_t mem [DEPTH];

  // -------------------------------------------------------------------------
  // request decode
  // -------------------------------------------------------------------------
  logic    acc;
  logic    full;
  logic    empty;
  logic    past_end;
  logic    need_rd;
  logic    need_scan;
  status_e st_dec;
  logic    scan_more;
  logic    out_load;

  logic    rd_en;
  addr_t   rd_addr;
  logic    wr_en;
  addr_t   wr_addr;
  word_t   wr_data;

  best_ctl_t best_ctl;
  word_t     best_r;

  assign full      = (count_r == CW'(DEPTH));
  assign empty     = (count_r == '0);
  assign past_end  = (CW'(in_data.position) >= count_r);
  assign scan_more = (scan_idx_r < count_r);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign acc       = in_valid && !in_stall;
  assign wr_data   = word_t'(in_data.value);

  always_comb begin
    need_rd   = 1'b0;
    need_scan = 1'b0;
    st_dec    = ST_OK;
    unique case (in_data.func)
      F_APPEND, F_INSERT: begin
        if (full) st_dec = ST_FULL;
      end
      F_POP: begin
        need_rd = !empty;
      end
      F_READ: begin
        if (empty) begin
          st_dec = ST_EMPTY;
        end else if (past_end) begin
          st_dec = ST_RANGE;
        end else begin
          need_rd = 1'b1;
        end
      end
      F_MAX, F_MIN: begin
        if (empty) begin
          st_dec = ST_EMPTY;
        end else begin
          need_scan = 1'b1;
        end
      end
      default: begin
        st_dec = ST_OK;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // next state
  // -------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          priority if (need_rd)   state_nxt = S_RD;
          else if (need_scan)     state_nxt = S_SCAN;
          else                    state_nxt = S_OUT;
        end
      end
      S_RD:   state_nxt = S_OUT;
      S_SCAN: begin
        // last word has been folded in once no read is left in flight
        if (!scan_more && !rd_vld_r) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // -------------------------------------------------------------------------
  // outputs of the sequencer: handshake and memory ports
  // -------------------------------------------------------------------------
  always_comb begin
    in_stall = 1'b1;
    rd_en    = 1'b0;
    rd_addr  = front_r;
    wr_en    = 1'b0;
    wr_addr  = front_r + count_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        rd_en    = acc && (need_rd || need_scan);
        if (in_data.func == F_POP) begin
          rd_addr = front_r + AW'(count_r - CW'(1));
        end else if (in_data.func == F_READ) begin
          rd_addr = front_r + AW'(in_data.position);
        end
        if (in_data.func == F_INSERT) begin
          wr_addr = front_r - AW'(1);
        end
        wr_en = acc && !full &&
                (in_data.func == F_APPEND || in_data.func == F_INSERT);
      end
      S_SCAN: begin
        rd_en   = scan_more;
        rd_addr = front_r + scan_idx_r[AW-1:0];
      end
      S_RD, S_OUT: begin
        in_stall = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // -------------------------------------------------------------------------
  // slot memory. Reads and writes to one slot never share a cycle: every
  // write happens at a transfer, and the next read is issued no earlier
  // than the following transfer.
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // -------------------------------------------------------------------------
  // running extreme for max / min
  // -------------------------------------------------------------------------
  assign best_ctl.start  = acc && need_scan;
  assign best_ctl.load   = rd_vld_r && (state_r == S_SCAN);
  assign best_ctl.is_max = is_max_r;

  ssmm_best u_best (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (best_ctl),
    .data   (rd_data_r),
    .best_r (best_r)
  );

  // -------------------------------------------------------------------------
  // control registers
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;

      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (acc) begin
        scan_idx_r <= CW'(1);
        unique case (in_data.func)
          F_APPEND: begin
            if (!full) count_r <= count_r + CW'(1);
          end
          F_INSERT: begin
            if (!full) begin
              front_r <= front_r - AW'(1);
              count_r <= count_r + CW'(1);
            end
          end
          F_POP: begin
            if (!empty) count_r <= count_r - CW'(1);
          end
          F_CLEAR: begin
            front_r <= '0;
            count_r <= '0;
          end
          default: begin
            count_r <= count_r;
          end
        endcase
      end else if (state_r == S_SCAN && scan_more) begin
        scan_idx_r <= scan_idx_r + CW'(1);
      end
    end
  end

  // -------------------------------------------------------------------------
  // pending result and output register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (acc) begin
      pend_res_r <= '0;
      pend_st_r  <= st_dec;
      is_max_r   <= (in_data.func == F_MAX);
    end else if (state_r == S_RD) begin
      pend_res_r <= field_word_t'(rd_data_r);
    end else if (state_r == S_SCAN && !scan_more && !rd_vld_r) begin
      pend_res_r <= field_word_t'(best_r);
    end

    if (out_load) begin
      out_r.result_value <= pend_res_r;
      out_r.status       <= pend_st_r;
      out_r.occupancy    <= 9'(count_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // -------------------------------------------------------------------------
  // checks
  // -------------------------------------------------------------------------
  // no slot is written while the store is full
  `SSMM_ASSERT_IMP(a_no_write_full, clk, rst_n, wr_en, count_r < CW'(DEPTH))
  // read data is always in flight when a pop or indexed read collects it
  `SSMM_ASSERT_IMP(a_rd_data_ready, clk, rst_n, state_r == S_RD, rd_vld_r)
  // an accepted request always leaves idle to produce its result
  `SSMM_ASSERT_NXT(a_acc_leaves_idle, clk, rst_n, acc, state_r != S_IDLE)
  // a finished result waits while the output register is blocked
  `SSMM_ASSERT_NXT(a_out_hold, clk, rst_n,
                   state_r == S_OUT && out_valid_r && out_stall,
                   state_r == S_OUT && out_valid_r)

endmodule

`default_nettype wire
